// File: hw/rtl/stps_pkg.sv
// shared constants, register indexes and exp table helpers for the plasticity synapse
`timescale 1ns / 1ps

package stps_pkg;

	localparam int EXP_TABLE_ENTRIES = 1024;
	localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);

	localparam int LEVEL_W = 17;
	localparam int RATE_W = 24;
	localparam int WEIGHT_W = 24;
	localparam int TIME_W = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FACIL = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_USE = 3'd4;

	// synapse modes
	localparam logic [1:0] MODE_CONST = 2'd0;
	localparam logic [1:0] MODE_DEP = 2'd1;
	localparam logic [1:0] MODE_FAC = 2'd2;

	// ratio between neighboring table entries, Q1.30, from a truncated taylor series
	localparam longint unsigned EXP_D = (64'd16 << 30) / EXP_TABLE_ENTRIES;
	localparam longint unsigned EXP_T0 = 64'd1 << 30;
	localparam longint unsigned EXP_T1 = (EXP_T0 * EXP_D) >> 30;
	localparam longint unsigned EXP_T2 = ((EXP_T1 * EXP_D) >> 30) / 2;
	localparam longint unsigned EXP_T3 = ((EXP_T2 * EXP_D) >> 30) / 3;
	localparam longint unsigned EXP_T4 = ((EXP_T3 * EXP_D) >> 30) / 4;
	localparam longint unsigned EXP_T5 = ((EXP_T4 * EXP_D) >> 30) / 5;
	localparam longint unsigned EXP_T6 = ((EXP_T5 * EXP_D) >> 30) / 6;
	localparam longint unsigned EXP_T7 = ((EXP_T6 * EXP_D) >> 30) / 7;
	localparam longint unsigned EXP_T8 = ((EXP_T7 * EXP_D) >> 30) / 8;
	localparam longint unsigned EXP_T9 = ((EXP_T8 * EXP_D) >> 30) / 9;
	localparam longint unsigned EXP_T10 = ((EXP_T9 * EXP_D) >> 30) / 10;
	localparam longint unsigned EXP_T11 = ((EXP_T10 * EXP_D) >> 30) / 11;
	localparam longint unsigned EXP_T12 = ((EXP_T11 * EXP_D) >> 30) / 12;
	localparam longint EXP_SUM = longint'(EXP_T0) - longint'(EXP_T1) + longint'(EXP_T2)
		- longint'(EXP_T3) + longint'(EXP_T4) - longint'(EXP_T5) + longint'(EXP_T6)
		- longint'(EXP_T7) + longint'(EXP_T8) - longint'(EXP_T9) + longint'(EXP_T10)
		- longint'(EXP_T11) + longint'(EXP_T12);

	localparam logic [30:0] EXP_R = 31'(EXP_SUM);

endpackage

// File: hw/rtl/stps_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module stps_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/short_term_plasticity_synapse.sv
// short-term plasticity synapse: exp table, shared multiplier and spike sequencer
// reset: the exp table is filled from its recurrence, one entry a cycle, for all
//   EXP_TABLE_ENTRIES entries (1024); spikes are stalled meanwhile, config writes are taken
// constant mode: the weight goes straight to the output word
// depressing mode: x multiply, table index, table read, apply to resources, psp, consume
// facilitating mode: decay steps for utilisation, then for resources, psp, raise and consume
// steps suit the single multiplier and table read; spikes wait until a result is loaded
`timescale 1ns / 1ps

module short_term_plasticity_synapse (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 spike_valid,
	output logic                                 spike_stall,
	input  logic [stps_pkg::TIME_W-1:0]          spike_time,
	output logic                                 psp_valid,
	input  logic                                 psp_stall,
	output logic signed [stps_pkg::WEIGHT_W-1:0] psp_amplitude,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [stps_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [stps_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [3:0] S_FILL = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_XMUL = 4'd2;
	localparam logic [3:0] S_IDX = 4'd3;
	localparam logic [3:0] S_RD = 4'd4;
	localparam logic [3:0] S_APPLY = 4'd5;
	localparam logic [3:0] S_PSP = 4'd6;
	localparam logic [3:0] S_CONS1 = 4'd7;
	localparam logic [3:0] S_CONS2 = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	localparam int LW = stps_pkg::LEVEL_W;
	localparam int IW = stps_pkg::IDX_W;

	logic [3:0] state_q;

	// configuration
	logic [1:0]                          mode_q;
	logic signed [stps_pkg::WEIGHT_W-1:0] weight_q;
	logic [stps_pkg::RATE_W-1:0]         recovery_rate_q;
	logic [stps_pkg::RATE_W-1:0]         facil_rate_q;
	logic [LW-1:0]                       use_q;

	// synapse state
	logic [LW-1:0]                 res_q;
	logic [LW-1:0]                 util_q;
	logic [stps_pkg::TIME_W-1:0]   last_q;

	// per-spike working registers
	logic [stps_pkg::TIME_W-1:0]   elapsed_q;
	logic                          fac_q;
	logic                          phase_fac_q;
	logic [55:0]                   p_q;
	logic                          over_q;
	logic signed [stps_pkg::WEIGHT_W-1:0] psp_q;

	// table fill
	logic [IW-1:0] fill_addr_q;
	logic [30:0]   v_q;
	logic [30:0]   v_round;

	// output word
	logic                                 out_valid_q;
	logic signed [stps_pkg::WEIGHT_W-1:0] out_amp_q;

	logic                 spike_take;
	logic                 out_load;
	logic [LW-1:0]        u_sat;
	logic [LW-1:0]        rdata;
	logic [LW-1:0]        e_val;
	logic signed [32:0]   mul_a;
	logic signed [32:0]   mul_b;
	logic signed [65:0]   prod;

	assign cfg_ready = 1'b1;
	assign spike_stall = (state_q != S_IDLE);
	assign spike_take = spike_valid && !spike_stall;
	assign psp_valid = out_valid_q;
	assign psp_amplitude = out_amp_q;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !psp_stall);

	assign u_sat = (use_q > stps_pkg::ONE_Q16) ? stps_pkg::ONE_Q16 : use_q;
	assign v_round = v_q + 31'd8192;
	assign e_val = over_q ? '0 : rdata;

	stps_ram #(
		.WIDTH(LW),
		.DEPTH(stps_pkg::EXP_TABLE_ENTRIES)
	) u_exp_ram (
		.clk   (clk),
		.we    (state_q == S_FILL),
		.waddr (fill_addr_q),
		.wdata (v_round[30:14]),
		.raddr (p_q[28 +: IW]),
		.rdata (rdata)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FILL: begin
				mul_a = {2'b00, v_q};
				mul_b = {2'b00, stps_pkg::EXP_R};
			end
			S_XMUL: begin
				mul_a = {1'b0, elapsed_q};
				mul_b = {9'd0, (phase_fac_q ? facil_rate_q : recovery_rate_q)};
			end
			S_IDX: begin
				mul_a = {5'd0, p_q[27:0]};
				mul_b = 33'(stps_pkg::EXP_TABLE_ENTRIES);
			end
			S_APPLY: begin
				mul_a = phase_fac_q ? {16'd0, util_q} : {16'd0, stps_pkg::ONE_Q16 - res_q};
				mul_b = {16'd0, e_val};
			end
			S_PSP: begin
				mul_a = {{9{weight_q[stps_pkg::WEIGHT_W-1]}}, weight_q};
				mul_b = {16'd0, res_q};
			end
			S_CONS1: begin
				mul_a = {16'd0, u_sat};
				mul_b = fac_q ? {16'd0, stps_pkg::ONE_Q16 - util_q} : {16'd0, res_q};
			end
			S_CONS2: begin
				mul_a = {16'd0, util_q};
				mul_b = {16'd0, res_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stps_pkg::MODE_DEP;
			weight_q <= 24'sd65536;
			recovery_rate_q <= 24'd167772;
			facil_rate_q <= 24'd167772;
			use_q <= 17'd32768;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				stps_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				stps_pkg::REG_WEIGHT: weight_q <= cfg_data;
				stps_pkg::REG_RECOVERY: recovery_rate_q <= cfg_data;
				stps_pkg::REG_FACIL: facil_rate_q <= cfg_data;
				stps_pkg::REG_USE: use_q <= cfg_data[LW-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			fill_addr_q <= '0;
			v_q <= 31'h4000_0000;
			res_q <= stps_pkg::ONE_Q16;
			util_q <= '0;
			last_q <= '0;
			fac_q <= 1'b0;
			phase_fac_q <= 1'b0;
		end else begin
			case (state_q)
				S_FILL: begin
					v_q <= prod[60:30];
					fill_addr_q <= fill_addr_q + 1'b1;
					if (fill_addr_q == IW'(stps_pkg::EXP_TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (spike_take) begin
						if (mode_q == stps_pkg::MODE_DEP || mode_q == stps_pkg::MODE_FAC) begin
							elapsed_q <= spike_time - last_q;
							last_q <= spike_time;
							fac_q <= (mode_q == stps_pkg::MODE_FAC);
							phase_fac_q <= (mode_q == stps_pkg::MODE_FAC);
							if (res_q > stps_pkg::ONE_Q16) begin
								res_q <= stps_pkg::ONE_Q16;
							end
							if (util_q > stps_pkg::ONE_Q16) begin
								util_q <= stps_pkg::ONE_Q16;
							end
							state_q <= S_XMUL;
						end else begin
							psp_q <= weight_q;
							state_q <= S_OUT;
						end
					end
				end
				S_XMUL: begin
					p_q <= prod[55:0];
					state_q <= S_IDX;
				end
				S_IDX: begin
					// x of sixteen or more gives a zero factor
					over_q <= |p_q[55:28];
					p_q <= prod[55:0];
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (phase_fac_q) begin
						util_q <= prod[32:16];
						phase_fac_q <= 1'b0;
						state_q <= S_XMUL;
					end else begin
						res_q <= stps_pkg::ONE_Q16 - prod[32:16];
						state_q <= S_PSP;
					end
				end
				S_PSP: begin
					// bits above the shift give the floor for negative weights
					psp_q <= prod[39:16];
					state_q <= S_CONS1;
				end
				S_CONS1: begin
					if (fac_q) begin
						util_q <= util_q + prod[32:16];
						state_q <= S_CONS2;
					end else begin
						res_q <= res_q - prod[32:16];
						state_q <= S_OUT;
					end
				end
				S_CONS2: begin
					res_q <= res_q - prod[32:16];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!psp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_amp_q <= psp_q;
		end
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		spike_take && (mode_q == stps_pkg::MODE_DEP || mode_q == stps_pkg::MODE_FAC)
		|=> last_q == $past(spike_time))
	else $error("last spike time not taken on accept");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && out_amp_q == $past(psp_q))
	else $error("result word not loaded");

	assert property (@(posedge clk) disable iff (!arst_n)
		spike_take |=> state_q != S_IDLE)
	else $error("accepted spike not processed");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> res_q <= stps_pkg::ONE_Q16 && util_q <= stps_pkg::ONE_Q16)
	else $error("level above one between spikes");

endmodule
